### rtl/core/tlik_pkg.sv
// Shared types, widths and constants for the two-link arm inverse kinematics core.
// Used by the square root, the CORDIC atan2 pipeline and the top level.
// No dependencies.
package tlik_pkg;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int Q16_FRAC = 16;
    localparam int ROUND_SHIFT = Q16_FRAC - ANGLE_FRAC_BITS;

    // Widths of the arithmetic path
    localparam int XY_W = 16;
    localparam int LEN_W = 15;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int LSQ_W = 2 * LEN_W;
    localparam int DSQ_W = 32;
    localparam int RS_W = 2 * LSQ_W;
    localparam int RD_W = LSQ_W + DSQ_W;
    localparam int NUM_W = 34;
    localparam int MAG_W = 32;
    localparam int NSQ_W = 2 * MAG_W;
    localparam int SQRT_STEPS = 32;
    localparam int DEN_W = 2 * SQRT_STEPS - 1;
    localparam int ROOT_W = SQRT_STEPS;
    localparam int CX_W = 34;
    localparam int Z_W = 27;
    localparam int LEAD_W = $clog2(MAG_W);
    localparam int NORM_TOP = 30;

    // Pipeline depth
    localparam int CORDIC_STEPS = 23;
    localparam int NORM_STAGES = 2;
    localparam int ATAN_STAGES = NORM_STAGES + CORDIC_STEPS;
    localparam int PRE_STAGES = 5;
    localparam int PIPE_DEPTH = PRE_STAGES + SQRT_STEPS + ATAN_STAGES + 1;

    // Angles in Q16 degrees
    localparam logic signed [Z_W-1:0] DEG90 = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0] DEG180 = Z_W'(180 * 65536);

    // Rounded atan(2^-i) in Q16 degrees
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945), Z_W'(234379),
        Z_W'(117304), Z_W'(58666), Z_W'(29335), Z_W'(14668), Z_W'(7334),
        Z_W'(3667), Z_W'(1833), Z_W'(917), Z_W'(458), Z_W'(229), Z_W'(115),
        Z_W'(57), Z_W'(29), Z_W'(14), Z_W'(7), Z_W'(4), Z_W'(2), Z_W'(1)
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER = 2'd0,
        CFG_LOWER = 2'd1,
        CFG_REACH = 2'd2
    } cfg_index_t;

    // Payloads
    typedef struct packed {
        logic signed [XY_W-1:0] target_x;
        logic signed [XY_W-1:0] target_y;
    } target_t;

    typedef struct packed {
        logic signed [16:0] shoulder_angle;
        logic [14:0]        elbow_angle;
        logic               beyond_reach;
        logic               clamped;
    } joint_t;

    // Arithmetic shift that truncates toward zero.
    function automatic logic signed [CX_W-1:0] shr_tz(input logic signed [CX_W-1:0] v,
                                                       input int s);
        logic [CX_W-1:0] m;
        m = v[CX_W-1] ? CX_W'(-v) : CX_W'(v);
        m = m >> s;
        return v[CX_W-1] ? $signed(-m) : $signed(m);
    endfunction

endpackage

### rtl/core/tlik_isqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on tlik_pkg.
module tlik_isqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [tlik_pkg::DEN_W-1:0]   rad,
    output logic [tlik_pkg::ROOT_W-1:0]  root
);
    import tlik_pkg::*;

    logic [NSQ_W-1:0] n_reg [SQRT_STEPS];
    logic [NSQ_W-1:0] n_next [SQRT_STEPS];
    logic [NSQ_W-1:0] r_reg [SQRT_STEPS];
    logic [NSQ_W-1:0] r_next [SQRT_STEPS];

    // One restoring step per stage, from the top bit pair down.
    always_comb
    begin
        logic [NSQ_W-1:0] n_in;
        logic [NSQ_W-1:0] r_in;
        logic [NSQ_W-1:0] trial;
        logic [NSQ_W-1:0] bitv;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            n_in = (k == 0) ? NSQ_W'(rad) : n_reg[(k == 0) ? 0 : k - 1];
            r_in = (k == 0) ? '0 : r_reg[(k == 0) ? 0 : k - 1];
            bitv = NSQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            trial = r_in + bitv;
            if (n_in >= trial)
            begin
                n_next[k] = n_in - trial;
                r_next[k] = (r_in >> 1) + bitv;
            end
            else
            begin
                n_next[k] = n_in;
                r_next[k] = r_in >> 1;
            end
        end
    end

    // Stage registers advance together.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

### rtl/core/tlik_atan2.sv
// Pipelined atan2 in Q16 degrees: normalize, quadrant fold, vectoring CORDIC.
// Depends on tlik_pkg.
module tlik_atan2 (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [tlik_pkg::CX_W-1:0]   xv,
    input  logic signed [tlik_pkg::CX_W-1:0]   yv,
    output logic signed [tlik_pkg::Z_W-1:0]    z
);
    import tlik_pkg::*;

    // Normalize stage one: magnitudes and leading one.
    logic [MAG_W-1:0]  ax_reg, ay_reg, ax_next, ay_next;
    logic              xneg_reg, yneg_reg, zero_reg, zero_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;

    always_comb
    begin
        logic [MAG_W-1:0] m;
        ax_next = xv[CX_W-1] ? MAG_W'(-xv) : MAG_W'(xv);
        ay_next = yv[CX_W-1] ? MAG_W'(-yv) : MAG_W'(yv);
        m = (ax_next > ay_next) ? ax_next : ay_next;
        zero_next = (m == '0);
        lead_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (m[i])
            begin
                lead_next = LEAD_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            xneg_reg <= xv[CX_W-1];
            yneg_reg <= yv[CX_W-1];
            zero_reg <= zero_next;
            lead_reg <= lead_next;
        end
    end

    // CORDIC state; index 0 holds the normalized and folded vector.
    logic signed [CX_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cx_next [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy_next [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cz_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cz_next [CORDIC_STEPS+1];
    logic                   zf_reg [CORDIC_STEPS+1];

    // Normalize stage two feeds entry 0; each later entry is one vectoring rotation.
    always_comb
    begin
        logic [MAG_W-1:0]       nx;
        logic [MAG_W-1:0]       ny;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        // Shift into [2^30, 2^31), restore signs, fold the left half plane.
        if (lead_reg >= LEAD_W'(NORM_TOP))
        begin
            nx = ax_reg >> (lead_reg - LEAD_W'(NORM_TOP));
            ny = ay_reg >> (lead_reg - LEAD_W'(NORM_TOP));
        end
        else
        begin
            nx = ax_reg << (LEAD_W'(NORM_TOP) - lead_reg);
            ny = ay_reg << (LEAD_W'(NORM_TOP) - lead_reg);
        end
        xs = $signed(CX_W'(nx));
        ys = $signed(CX_W'(ny));
        if (xneg_reg)
        begin
            xs = -xs;
        end
        if (yneg_reg)
        begin
            ys = -ys;
        end
        if (xs[CX_W-1] && !ys[CX_W-1])
        begin
            cx_next[0] = ys;
            cy_next[0] = -xs;
            cz_next[0] = DEG90;
        end
        else if (xs[CX_W-1])
        begin
            cx_next[0] = -ys;
            cy_next[0] = xs;
            cz_next[0] = -DEG90;
        end
        else
        begin
            cx_next[0] = xs;
            cy_next[0] = ys;
            cz_next[0] = '0;
        end
        // One vectoring rotation per stage.
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = shr_tz(cy_reg[i], i);
            dy = shr_tz(cx_reg[i], i);
            if (!cy_reg[i][CX_W-1])
            begin
                cx_next[i+1] = cx_reg[i] + dx;
                cy_next[i+1] = cy_reg[i] - dy;
                cz_next[i+1] = cz_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                cx_next[i+1] = cx_reg[i] - dx;
                cy_next[i+1] = cy_reg[i] + dy;
                cz_next[i+1] = cz_reg[i] - ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zf_reg[0] <= zero_reg;
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                zf_reg[i] <= zf_reg[i-1];
            end
        end
    end

    // A zero vector gives zero degrees.
    assign z = zf_reg[CORDIC_STEPS] ? '0 : cz_reg[CORDIC_STEPS];

endmodule

### rtl/core/two_link_arm_inverse_kinematics.sv
// Top level of the two-link planar arm inverse kinematics core.
// Depends on tlik_pkg, tlik_isqrt and tlik_atan2.
//
//  Channel   Signals                                   Direction  Payload
//  target    target_valid, target_stall, target        in         tlik_pkg::target_t
//  joint     joint_valid, joint_stall, joint           out        tlik_pkg::joint_t
//  config    cfg_write, cfg_index, cfg_data            in         32-bit register write
//
// One target enters per cycle while target_stall is low; the result leaves after its transfer through
// 5 setup stages, 32 square root stages, 25 atan2 stages, a combine stage and the output buffer.
// The whole pipeline advances as one; it holds only when the two-entry output buffer is full.
// target_stall comes from the buffer fill count alone, not from joint_stall directly.
// Reset clears the configuration registers, the valid bits and the output buffer.
module two_link_arm_inverse_kinematics (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            target_valid,
    output logic                            target_stall,
    input  tlik_pkg::target_t               target,
    output logic                            joint_valid,
    input  logic                            joint_stall,
    output tlik_pkg::joint_t                joint,
    input  logic                            cfg_write,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlik_pkg::CFG_W-1:0]      cfg_data
);
    import tlik_pkg::*;

    typedef struct packed {
        logic beyond;
        logic dzero;
        logic over_el;
        logic over_sh;
        logic den0_el;
        logic den0_sh;
        logic pos_el;
        logic pos_sh;
    } flag_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [NUM_W-1:0] num_el;
        logic signed [NUM_W-1:0] num_sh;
        flag_t                   fl;
    } side_t;

    // Configuration registers
    logic [LEN_W-1:0] upper_reg, lower_reg;
    logic [DSQ_W-1:0] reach_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            lower_reg <= '0;
            reach_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_UPPER: upper_reg <= cfg_data[LEN_W-1:0];
                CFG_LOWER: lower_reg <= cfg_data[LEN_W-1:0];
                CFG_REACH: reach_reg <= cfg_data[DSQ_W-1:0];
                default:   ;
            endcase
        end
    end

    // Pipeline advance and valid bits
    logic [1:0] count_reg, count_next;
    logic       adv, push, pop;
    logic [PIPE_DEPTH-1:0] v_reg;

    assign adv = (count_reg != 2'd2);
    assign target_stall = !adv;
    assign push = adv && v_reg[PIPE_DEPTH-1];
    assign pop = joint_valid && !joint_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], target_valid};
        end
    end

    // Stage A: squares of the coordinates and link lengths.
    logic signed [XY_W-1:0] a_x_reg, a_y_reg;
    logic [DSQ_W-1:0]       a_xx_reg, a_yy_reg, a_xx_next, a_yy_next;
    logic [LSQ_W-1:0]       a_rsq_reg, a_ssq_reg, a_rsq_next, a_ssq_next;

    always_comb
    begin
        a_xx_next = DSQ_W'(DSQ_W'(target.target_x) * DSQ_W'(target.target_x));
        a_yy_next = DSQ_W'(DSQ_W'(target.target_y) * DSQ_W'(target.target_y));
        a_rsq_next = LSQ_W'(upper_reg) * LSQ_W'(upper_reg);
        a_ssq_next = LSQ_W'(lower_reg) * LSQ_W'(lower_reg);
    end

    // Stage B: squared distance and product of the squared lengths.
    logic signed [XY_W-1:0] b_x_reg, b_y_reg;
    logic [DSQ_W-1:0]       b_dsq_reg, b_dsq_next;
    logic [RS_W-1:0]        b_rs_reg, b_rs_next;
    logic [LSQ_W-1:0]       b_rsq_reg, b_ssq_reg;

    always_comb
    begin
        b_dsq_next = a_xx_reg + a_yy_reg;
        b_rs_next = RS_W'(a_rsq_reg) * RS_W'(a_ssq_reg);
    end

    // Stage C: numerators, elbow denominator, reach test.
    logic signed [XY_W-1:0]  c_x_reg, c_y_reg;
    logic [RD_W-1:0]         c_rd_reg, c_rd_next;
    logic signed [NUM_W-1:0] c_num_el_reg, c_num_sh_reg, c_num_el_next, c_num_sh_next;
    logic [DEN_W-1:0]        c_den_el_reg, c_den_el_next;
    logic                    c_beyond_reg, c_dzero_reg, c_beyond_next, c_dzero_next;

    always_comb
    begin
        c_rd_next = RD_W'(b_rsq_reg) * RD_W'(b_dsq_reg);
        c_num_el_next = $signed(NUM_W'(b_rsq_reg)) + $signed(NUM_W'(b_ssq_reg))
                      - $signed(NUM_W'(b_dsq_reg));
        c_num_sh_next = $signed(NUM_W'(b_rsq_reg)) + $signed(NUM_W'(b_dsq_reg))
                      - $signed(NUM_W'(b_ssq_reg));
        c_den_el_next = DEN_W'({b_rs_reg, 2'b00});
        c_beyond_next = b_dsq_reg > reach_reg;
        c_dzero_next = (b_dsq_reg == '0);
    end

    // Stage D: squared numerators and shoulder denominator.
    logic signed [XY_W-1:0]  d_x_reg, d_y_reg;
    logic [NSQ_W-1:0]        d_nsq_el_reg, d_nsq_sh_reg, d_nsq_el_next, d_nsq_sh_next;
    logic [DEN_W-1:0]        d_den_el_reg, d_den_sh_reg, d_den_sh_next;
    logic signed [NUM_W-1:0] d_num_el_reg, d_num_sh_reg;
    logic                    d_beyond_reg, d_dzero_reg;

    always_comb
    begin
        logic [MAG_W-1:0] mag_el;
        logic [MAG_W-1:0] mag_sh;
        mag_el = c_num_el_reg[NUM_W-1] ? MAG_W'(-c_num_el_reg) : MAG_W'(c_num_el_reg);
        mag_sh = c_num_sh_reg[NUM_W-1] ? MAG_W'(-c_num_sh_reg) : MAG_W'(c_num_sh_reg);
        d_nsq_el_next = NSQ_W'(mag_el) * NSQ_W'(mag_el);
        d_nsq_sh_next = NSQ_W'(mag_sh) * NSQ_W'(mag_sh);
        d_den_sh_next = DEN_W'({c_rd_reg, 2'b00});
    end

    // Stage E: acos range checks and square root radicands.
    logic [DEN_W-1:0] e_rad_el_reg, e_rad_sh_reg, e_rad_el_next, e_rad_sh_next;
    side_t            e_side_reg, e_side_next;

    always_comb
    begin
        e_rad_el_next = DEN_W'(NSQ_W'(d_den_el_reg) - d_nsq_el_reg);
        e_rad_sh_next = DEN_W'(NSQ_W'(d_den_sh_reg) - d_nsq_sh_reg);
        e_side_next.x = d_x_reg;
        e_side_next.y = d_y_reg;
        e_side_next.num_el = d_num_el_reg;
        e_side_next.num_sh = d_num_sh_reg;
        e_side_next.fl.beyond = d_beyond_reg;
        e_side_next.fl.dzero = d_dzero_reg;
        e_side_next.fl.over_el = d_nsq_el_reg > NSQ_W'(d_den_el_reg);
        e_side_next.fl.over_sh = d_nsq_sh_reg > NSQ_W'(d_den_sh_reg);
        e_side_next.fl.den0_el = (d_den_el_reg == '0);
        e_side_next.fl.den0_sh = (d_den_sh_reg == '0);
        e_side_next.fl.pos_el = !d_num_el_reg[NUM_W-1] && (d_num_el_reg != '0);
        e_side_next.fl.pos_sh = !d_num_sh_reg[NUM_W-1] && (d_num_sh_reg != '0);
    end

    // Registers of stages A to E
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg <= target.target_x;
            a_y_reg <= target.target_y;
            a_xx_reg <= a_xx_next;
            a_yy_reg <= a_yy_next;
            a_rsq_reg <= a_rsq_next;
            a_ssq_reg <= a_ssq_next;

            b_x_reg <= a_x_reg;
            b_y_reg <= a_y_reg;
            b_dsq_reg <= b_dsq_next;
            b_rs_reg <= b_rs_next;
            b_rsq_reg <= a_rsq_reg;
            b_ssq_reg <= a_ssq_reg;

            c_x_reg <= b_x_reg;
            c_y_reg <= b_y_reg;
            c_rd_reg <= c_rd_next;
            c_num_el_reg <= c_num_el_next;
            c_num_sh_reg <= c_num_sh_next;
            c_den_el_reg <= c_den_el_next;
            c_beyond_reg <= c_beyond_next;
            c_dzero_reg <= c_dzero_next;

            d_x_reg <= c_x_reg;
            d_y_reg <= c_y_reg;
            d_nsq_el_reg <= d_nsq_el_next;
            d_nsq_sh_reg <= d_nsq_sh_next;
            d_den_el_reg <= c_den_el_reg;
            d_den_sh_reg <= d_den_sh_next;
            d_num_el_reg <= c_num_el_reg;
            d_num_sh_reg <= c_num_sh_reg;
            d_beyond_reg <= c_beyond_reg;
            d_dzero_reg <= c_dzero_reg;

            e_rad_el_reg <= e_rad_el_next;
            e_rad_sh_reg <= e_rad_sh_next;
            e_side_reg <= e_side_next;
        end
    end

    // Square roots, with side data delayed alongside.
    logic [ROOT_W-1:0] root_el, root_sh;
    side_t             sd_reg [SQRT_STEPS];

    tlik_isqrt u_isqrt_el (
        .clk  (clk),
        .en   (adv),
        .rad  (e_rad_el_reg),
        .root (root_el)
    );

    tlik_isqrt u_isqrt_sh (
        .clk  (clk),
        .en   (adv),
        .rad  (e_rad_sh_reg),
        .root (root_sh)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= e_side_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // Three atan2 pipelines: target direction and the two acos terms.
    side_t                  sq_side;
    logic signed [Z_W-1:0]  z_tg, z_el, z_sh;
    logic signed [CX_W-1:0] tg_xv, tg_yv, el_xv, el_yv, sh_xv, sh_yv;
    flag_t                  fd_reg [ATAN_STAGES];

    assign sq_side = sd_reg[SQRT_STEPS-1];
    assign tg_xv = CX_W'(sq_side.x);
    assign tg_yv = CX_W'(sq_side.y);
    assign el_xv = CX_W'(sq_side.num_el);
    assign el_yv = $signed(CX_W'(root_el));
    assign sh_xv = CX_W'(sq_side.num_sh);
    assign sh_yv = $signed(CX_W'(root_sh));

    tlik_atan2 u_atan_tg (
        .clk (clk),
        .en  (adv),
        .xv  (tg_xv),
        .yv  (tg_yv),
        .z   (z_tg)
    );

    tlik_atan2 u_atan_el (
        .clk (clk),
        .en  (adv),
        .xv  (el_xv),
        .yv  (el_yv),
        .z   (z_el)
    );

    tlik_atan2 u_atan_sh (
        .clk (clk),
        .en  (adv),
        .xv  (sh_xv),
        .yv  (sh_yv),
        .z   (z_sh)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fd_reg[0] <= sq_side.fl;
            for (int k = 1; k < ATAN_STAGES; k++)
            begin
                fd_reg[k] <= fd_reg[k-1];
            end
        end
    end

    // Stage F: pick special cases and sum the shoulder angle.
    flag_t                 fl;
    logic signed [Z_W-1:0] f_sh_reg, f_el_reg, f_sh_next, f_el_next;
    logic                  f_beyond_reg, f_clamp_reg, f_clamp_next;

    assign fl = fd_reg[ATAN_STAGES-1];

    always_comb
    begin
        logic signed [Z_W-1:0] q_tg;
        logic signed [Z_W-1:0] q_el;
        logic signed [Z_W-1:0] q_sh;
        // Direction angle limited to the half turn either way.
        q_tg = z_tg;
        if (q_tg > DEG180)
        begin
            q_tg = DEG180;
        end
        else if (q_tg < -DEG180)
        begin
            q_tg = -DEG180;
        end
        // Elbow acos term: an argument past one end of the range pins the angle.
        if (fl.over_el)
        begin
            q_el = fl.pos_el ? '0 : DEG180;
        end
        else if (fl.den0_el || z_el[Z_W-1])
        begin
            q_el = '0;
        end
        else
        begin
            q_el = (z_el > DEG180) ? DEG180 : z_el;
        end
        // Shoulder acos term, same rules.
        if (fl.over_sh)
        begin
            q_sh = fl.pos_sh ? '0 : DEG180;
        end
        else if (fl.den0_sh || z_sh[Z_W-1])
        begin
            q_sh = '0;
        end
        else
        begin
            q_sh = (z_sh > DEG180) ? DEG180 : z_sh;
        end
        if (fl.beyond)
        begin
            f_sh_next = q_tg + DEG90;
            f_el_next = DEG180;
            f_clamp_next = 1'b0;
        end
        else if (fl.dzero)
        begin
            f_sh_next = DEG90;
            f_el_next = q_el;
            f_clamp_next = 1'b1;
        end
        else
        begin
            f_sh_next = q_tg + DEG90 + q_sh;
            f_el_next = q_el;
            f_clamp_next = fl.over_el || fl.den0_el || fl.over_sh || fl.den0_sh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_sh_reg <= f_sh_next;
            f_el_reg <= f_el_next;
            f_beyond_reg <= fd_reg[ATAN_STAGES-1].beyond;
            f_clamp_reg <= f_clamp_next;
        end
    end

    // Round Q16 degrees half up to the output scale.
    joint_t                res;
    logic signed [Z_W-1:0] sh_round, el_round;

    assign sh_round = (f_sh_reg + Z_W'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    assign el_round = (f_el_reg + Z_W'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;

    always_comb
    begin
        res.shoulder_angle = sh_round[16:0];
        res.elbow_angle = el_round[14:0];
        res.beyond_reach = f_beyond_reg;
        res.clamped = f_clamp_reg;
    end

    // Two-entry output buffer
    joint_t fifo_reg [2];
    logic   wr_ptr_reg, rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    assign joint_valid = (count_reg != 2'd0);
    assign joint = fifo_reg[rd_ptr_reg];

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("output buffer count did not drop on a lone transfer");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |=> $stable(v_reg) || (count_reg != 2'd2) || $past(pop))
        else $error("pipeline moved while the output buffer was full");

    a_straight_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (joint_valid && joint.beyond_reach) |->
            (joint.elbow_angle == 15'(180 << ANGLE_FRAC_BITS)) && !joint.clamped)
        else $error("out-of-reach result is not a straight arm");

    a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
        joint_valid |-> (joint.elbow_angle <= 15'(180 << ANGLE_FRAC_BITS)))
        else $error("elbow angle above a half turn");

endmodule

### test/two_link_arm_inverse_kinematics_check.sv
// Checker for the two-link arm inverse kinematics core: watches both channels
// and the register port, predicts each joint result and compares field by field.
// Depends on tlik_pkg for the payload types and register indexes.
module two_link_arm_inverse_kinematics_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            target_valid,
    input  logic                            target_stall,
    input  tlik_pkg::target_t               target,
    input  logic                            joint_valid,
    input  logic                            joint_stall,
    input  tlik_pkg::joint_t                joint,
    input  logic                            cfg_write,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlik_pkg::CFG_W-1:0]      cfg_data,
    output int                              errors,
    output int                              pending,
    output int                              checked,
    output int                              beyond_seen,
    output int                              clamped_seen
);
    import tlik_pkg::*;

    localparam longint Q90 = 90 * 65536;
    localparam longint Q180 = 180 * 65536;
    localparam int ANG_SHIFT = 16 - 7;
    localparam longint ARCTAN_Q16 [23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    // Shadow copies of the link lengths and the reach limit.
    longint unsigned upper_len, lower_len, reach_sq;
    joint_t joint_expected [$];

    // Shift right, truncating toward zero.
    function automatic longint shift_toward_zero(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v) >>> s);
    endfunction

    // Floor square root, bit by bit.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC atan2 in Q16 degrees, clamped to a half turn each way.
    function automatic longint atan2_deg(longint xv, longint yv);
        longint unsigned ax, ay, m;
        longint x, y, z, t, dx, dy;
        ax = xv < 0 ? -xv : xv;
        ay = yv < 0 ? -yv : yv;
        m = ax > ay ? ax : ay;
        z = 0;
        if (m == 0)
            return 0;
        while (m >= (64'd1 << 31))
        begin
            ax = ax >> 1;
            ay = ay >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 30))
        begin
            ax = ax << 1;
            ay = ay << 1;
            m = m << 1;
        end
        x = xv < 0 ? -longint'(ax) : longint'(ax);
        y = yv < 0 ? -longint'(ay) : longint'(ay);
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = Q90;
            end
            else
            begin
                x = -y;
                y = t;
                z = -Q90;
            end
        end
        for (int i = 0; i < 23; i++)
        begin
            dx = shift_toward_zero(y, i);
            dy = shift_toward_zero(x, i);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q16[i];
            end
        end
        if (z > Q180) z = Q180;
        if (z < -Q180) z = -Q180;
        return z;
    endfunction

    // Arc cosine of num / sqrt(den_sq), with out-of-range arguments clamped.
    function automatic longint acos_deg(longint num, longint unsigned den_sq, inout bit clip);
        longint unsigned an, nsq;
        longint a;
        an = num < 0 ? -num : num;
        nsq = an * an;
        if (nsq > den_sq)
        begin
            clip = 1'b1;
            return num > 0 ? 0 : Q180;
        end
        if (den_sq == 0)
        begin
            clip = 1'b1;
            return 0;
        end
        a = atan2_deg(num, longint'(floor_sqrt(den_sq - nsq)));
        if (a < 0) a = 0;
        if (a > Q180) a = Q180;
        return a;
    endfunction

    // Round half up from Q16 degrees to the output angle format.
    function automatic longint to_angle(longint q);
        longint unsigned u;
        u = q + 360 * 65536;
        u = (u + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
        return longint'(u) - (360 << 7);
    endfunction

    function automatic joint_t solve_joints(target_t t);
        longint x, y, sh, el, num;
        longint unsigned dsq, rsq, ssq;
        bit far, clip;
        joint_t j;
        x = t.target_x;
        y = t.target_y;
        dsq = x * x + y * y;
        rsq = upper_len * upper_len;
        ssq = lower_len * lower_len;
        far = dsq > reach_sq;
        clip = 1'b0;
        if (far)
        begin
            sh = atan2_deg(x, y) + Q90;
            el = Q180;
        end
        else
        begin
            el = acos_deg(longint'(rsq + ssq) - longint'(dsq), 4 * rsq * ssq, clip);
            if (dsq == 0)
            begin
                clip = 1'b1;
                sh = Q90;
            end
            else
            begin
                num = longint'(rsq + dsq) - longint'(ssq);
                sh = atan2_deg(x, y) + Q90 + acos_deg(num, 4 * rsq * dsq, clip);
            end
        end
        j.shoulder_angle = 17'(to_angle(sh));
        j.elbow_angle = 15'(to_angle(el));
        j.beyond_reach = far;
        j.clamped = clip;
        return j;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch on joint %0d, %s: got %0d, expected %0d", checked, field, got, want);
        errors++;
    endtask

    assign pending = joint_expected.size();

    // Track register writes, predict on each target transfer, compare each joint transfer.
    always @(posedge clk or negedge rst_n)
    begin
        joint_t want;
        if (!rst_n)
        begin
            upper_len <= 0;
            lower_len <= 0;
            reach_sq <= 0;
            errors = 0;
            checked = 0;
            beyond_seen = 0;
            clamped_seen = 0;
            joint_expected.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_UPPER: upper_len <= cfg_data[14:0];
                    CFG_LOWER: lower_len <= cfg_data[14:0];
                    CFG_REACH: reach_sq <= cfg_data;
                    default: ;
                endcase
            end
            if (target_valid && !target_stall)
                joint_expected.push_back(solve_joints(target));
            if (joint_valid && !joint_stall)
            begin
                if (joint_expected.size() == 0)
                begin
                    $display("joint transfer with no target waiting");
                    errors++;
                end
                else
                begin
                    want = joint_expected.pop_front();
                    if (joint.shoulder_angle !== want.shoulder_angle)
                        report("shoulder_angle", joint.shoulder_angle, want.shoulder_angle);
                    if (joint.elbow_angle !== want.elbow_angle)
                        report("elbow_angle", joint.elbow_angle, want.elbow_angle);
                    if (joint.beyond_reach !== want.beyond_reach)
                        report("beyond_reach", joint.beyond_reach, want.beyond_reach);
                    if (joint.clamped !== want.clamped)
                        report("clamped", joint.clamped, want.clamped);
                    beyond_seen += want.beyond_reach;
                    clamped_seen += want.clamped;
                end
                checked++;
            end
        end
    end

endmodule

### test/two_link_arm_inverse_kinematics_test.sv
// Testbench top for the two-link arm inverse kinematics core: drives targets,
// register writes and output stalls, and gives the verdict.
// Depends on tlik_pkg, the core and two_link_arm_inverse_kinematics_check.
module two_link_arm_inverse_kinematics_test;
    import tlik_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic target_valid = 1'b0;
    logic target_stall;
    target_t target = '0;
    logic joint_valid;
    logic joint_stall = 1'b0;
    joint_t joint;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    int errors, pending, checked, beyond_seen, clamped_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cfg_sets = 0;

    two_link_arm_inverse_kinematics i_dut (
        .clk(clk), .rst_n(rst_n),
        .target_valid(target_valid), .target_stall(target_stall), .target(target),
        .joint_valid(joint_valid), .joint_stall(joint_stall), .joint(joint),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    two_link_arm_inverse_kinematics_check i_check (
        .clk(clk), .rst_n(rst_n),
        .target_valid(target_valid), .target_stall(target_stall), .target(target),
        .joint_valid(joint_valid), .joint_stall(joint_stall), .joint(joint),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked),
        .beyond_seen(beyond_seen), .clamped_seen(clamped_seen)
    );

    always #5 clk = ~clk;

    // Receiver stalls at random.
    always @(negedge clk)
        joint_stall <= ($urandom_range(99) < recv_idle_pct);

    initial
    begin
        #3_000_000;
        $display("timeout");
        $display("two_link_arm_inverse_kinematics_test: errors");
        $finish;
    end

    // One target transfer, with random idle cycles before it.
    task automatic send_target(logic signed [15:0] x, logic signed [15:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            target_valid <= 1'b0;
            @(negedge clk);
        end
        target_valid <= 1'b1;
        target <= '{target_x: x, target_y: y};
        do
            @(posedge clk);
        while (target_stall);
        @(negedge clk);
    endtask

    // Stop sending and wait until every joint result has come back.
    task automatic drain();
        target_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_arm(int upper, int lower, logic [31:0] reach);
        drain();
        write_reg(CFG_UPPER, 32'(upper));
        write_reg(CFG_LOWER, 32'(lower));
        write_reg(CFG_REACH, reach);
        cfg_sets++;
    endtask

    // A random target: mostly within the arm's span, some anywhere, some at corners.
    task automatic random_target(int span);
        int pick;
        logic signed [15:0] x, y;
        pick = $urandom_range(99);
        if (span > 32767) span = 32767;
        if (pick < 65)
        begin
            x = 16'($signed($urandom_range(0, 2 * span)) - span);
            y = 16'($signed($urandom_range(0, 2 * span)) - span);
        end
        else if (pick < 88)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        else
        begin
            case ($urandom_range(4))
                0: x = 16'sd0;
                1: x = 16'sd1;
                2: x = -16'sd1;
                3: x = 16'sh7fff;
                default: x = 16'sh8000;
            endcase
            y = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
        end
        send_target(x, y);
    endtask

    // A block of random targets under one random or extreme arm setting.
    task automatic random_block(int count);
        int upper, lower, span;
        logic [31:0] reach;
        case ($urandom_range(5))
            0: begin upper = 32767; lower = 32767; end
            1: begin upper = 0; lower = $urandom_range(32767); end
            2: begin upper = $urandom_range(1, 256); lower = $urandom_range(1, 256); end
            default: begin upper = $urandom_range(32767); lower = $urandom_range(32767); end
        endcase
        span = (upper + lower) / 2 + 16;
        case ($urandom_range(4))
            0: reach = 32'h8000_0000;
            1: reach = 32'(longint'(span) * span);
            2: reach = $urandom_range(0, 32'h7fff_ffff);
            3: reach = 0;
            default: reach = 32'(longint'(upper + lower) * (upper + lower) / 4);
        endcase
        set_arm(upper, lower, reach);
        repeat (count) random_target(span);
    endtask

    task automatic random_phase(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n += 50)
            random_block(50);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: every target but the origin is beyond reach.
        send_target(16'sd0, 16'sd0);
        send_target(16'sh7fff, 16'sh7fff);
        send_target(16'sh8000, 16'sh8000);
        send_target(-16'sd1, 16'sd0);
        send_target(16'sd0, -16'sd1);

        // Long links and full reach: extremes, axes and clamped arguments.
        set_arm(32767, 32767, 32'h8000_0000);
        send_target(16'sd0, 16'sd0);
        send_target(16'sh7fff, 16'sh7fff);
        send_target(16'sh8000, 16'sh8000);
        send_target(16'sh8000, 16'sd0);
        send_target(16'sd0, 16'sh8000);
        send_target(16'sh7fff, 16'sh8000);
        send_target(16'sd1, 16'sd0);
        send_target(16'sd0, 16'sd1);
        send_target(-16'sd1, -16'sd1);

        // Short links: far targets push the acos arguments past one.
        set_arm(4096, 2048, 32'h8000_0000);
        send_target(16'sd6144, 16'sd0);
        send_target(16'sd0, -16'sd2048);
        send_target(-16'sd1000, 16'sd20000);
        send_target(16'sd100, 16'sd100);

        // A zero link length gives a zero denominator.
        set_arm(0, 0, 32'h8000_0000);
        send_target(16'sd0, 16'sd0);
        send_target(16'sd500, -16'sd700);
        set_arm(3000, 3000, 32'd36_000_000);
        send_target(16'sd6000, 16'sd0);
        send_target(16'sd6001, 16'sd0);

        random_phase(34, 68, 550);
        random_phase(68, 34, 550);
        random_phase(0, 0, 550);
        drain();

        $display("%0d joint results checked over %0d arm settings", checked, cfg_sets);
        $display("%0d beyond reach, %0d with a clamped argument", beyond_seen, clamped_seen);
        if (errors == 0 && pending == 0)
            $display("two_link_arm_inverse_kinematics_test: clean");
        else
            $display("two_link_arm_inverse_kinematics_test: errors");
        $finish;
    end

endmodule
